// ===== hdl/dqp_pkg.sv =====
`timescale 1ns / 1ps

package dqp_pkg;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  localparam logic [1:0] LastOctet = 2'd3;
  localparam logic [1:0] MaxDigits = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
  } dqp_in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] octet_first;
    logic [7:0] octet_second;
    logic [7:0] octet_third;
    logic [7:0] octet_fourth;
  } dqp_out_t;

  typedef struct packed {
    logic     valid;
    dqp_out_t data;
  } dqp_res_t;

endpackage

// ===== hdl/dotted_quad_ipv4_parser.sv =====
`timescale 1ns / 1ps
// Each result is registered in the result register or, if it is held, in the skid entry.
// One character per cycle unless stalled; each accepted one updates the parse state.
// A result register plus one skid entry let input continue while a result waits.
// Input stalls only while both the result register and the skid entry are full.
// Reset (asynchronous, active low) clears the parse state and both output entries.
module dotted_quad_ipv4_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dqp_pkg::dqp_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dqp_pkg::dqp_out_t out_data_o
);

  logic              in_acc;
  logic              pop;
  dqp_pkg::dqp_res_t res;

  logic              out_valid_q;
  dqp_pkg::dqp_out_t out_data_q;
  logic              skid_valid_q;
  dqp_pkg::dqp_out_t skid_data_q;

  assign in_acc = in_valid_i & ~skid_valid_q;
  assign pop    = out_valid_q & ~out_stall_i;

  dqp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (res.valid) begin
      if (!out_valid_q || pop) begin
        out_data_q <= res.data;
      end else begin
        skid_data_q <= res.data;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/dqp_parse.sv =====
`timescale 1ns / 1ps

// Holds the per-string parse state and works out the result of one character.
module dqp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  dqp_pkg::dqp_in_t in_data_i,
  output dqp_pkg::dqp_res_t res_o
);

  logic       active_q, active_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] cnt_q, cnt_d;
  logic [9:0] acc_q, acc_d;
  logic [7:0] fin_q [3];
  logic [7:0] fin_d [3];

  logic       act_e;
  logic [1:0] idx_e;
  logic [1:0] cnt_e;
  logic [9:0] acc_e;
  logic [7:0] fin_e [3];
  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] ch;

  always_comb begin
    ch       = in_data_i.char_code;
    is_digit = (ch >= dqp_pkg::CharZero) && (ch <= dqp_pkg::CharNine);
    digit    = 4'(ch - dqp_pkg::CharZero);

    act_e = in_data_i.first_char | active_q;
    idx_e = in_data_i.first_char ? 2'd0 : idx_q;
    cnt_e = in_data_i.first_char ? 2'd0 : cnt_q;
    acc_e = in_data_i.first_char ? 10'd0 : acc_q;
    for (int i = 0; i < 3; i++) begin
      fin_e[i] = in_data_i.first_char ? 8'd0 : fin_q[i];
    end

    active_d = act_e;
    idx_d    = idx_e;
    cnt_d    = cnt_e;
    acc_d    = acc_e;
    fin_d    = fin_e;

    res_o                    = '0;
    res_o.data.status        = dqp_pkg::StatusFail;

    if (act_e) begin
      if (is_digit) begin
        if (cnt_e == dqp_pkg::MaxDigits) begin
          res_o.valid = 1'b1;
          active_d    = 1'b0;
        end else begin
          acc_d = 10'({acc_e, 3'b000} + {acc_e, 1'b0} + {6'd0, digit});
          cnt_d = cnt_e + 2'd1;
        end
      end else if (idx_e != dqp_pkg::LastOctet) begin
        if ((ch == dqp_pkg::CharDot) || (ch == dqp_pkg::CharNl)) begin
          fin_d[idx_e] = acc_e[7:0];
          idx_d        = idx_e + 2'd1;
          cnt_d        = 2'd0;
          acc_d        = 10'd0;
        end else begin
          res_o.valid = 1'b1;
          active_d    = 1'b0;
        end
      end else begin
        res_o.valid = 1'b1;
        active_d    = 1'b0;
        if ((ch == dqp_pkg::CharSpace) || (ch == dqp_pkg::CharNul) ||
            (ch == dqp_pkg::CharNl)) begin
          res_o.data.status       = dqp_pkg::StatusOk;
          res_o.data.octet_first  = fin_e[0];
          res_o.data.octet_second = fin_e[1];
          res_o.data.octet_third  = fin_e[2];
          res_o.data.octet_fourth = acc_e[7:0];
        end
      end
    end

    if (!accept_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= 2'd0;
      cnt_q    <= 2'd0;
      acc_q    <= 10'd0;
      for (int i = 0; i < 3; i++) begin
        fin_q[i] <= 8'd0;
      end
    end else if (accept_i) begin
      active_q <= active_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      fin_q    <= fin_d;
    end
  end

endmodule

// ===== hdl/dqp_checker.sv =====
`timescale 1ns / 1ps

module dqp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dqp_pkg::dqp_out_t out_data_o
);

  // The input can only stall when a result is already waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

  // The skid entry fills only when the result was held back in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a prior output stall");

  // A failed parse carries zero octets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == dqp_pkg::StatusFail)) |->
      (out_data_o.octet_first == 8'd0) && (out_data_o.octet_second == 8'd0) &&
      (out_data_o.octet_third == 8'd0) && (out_data_o.octet_fourth == 8'd0))
    else $error("failure result with nonzero octets");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind dotted_quad_ipv4_parser dqp_checker u_dqp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
